/* src/lzf80_pkg.sv */
package lzf80_pkg;

    // Fixed field widths
    localparam int LEN_W  = 17;    // expected length and write pointer compare width
    localparam int PTR_W  = 16;    // source pointer and output index width
    localparam int CNT_W  = 16;    // run count width
    localparam int BYTE_W = 8;

    localparam int OUT_SIZE_DEF = 65536;

    // Opcode constants
    localparam logic [7:0] OP_LONG_FILL  = 8'hFE;
    localparam logic [5:0] CNT_LONG_BASE = 6'h3E;   // counts at or above select long forms
    localparam logic [CNT_W-1:0] SHORT_CNT_BIAS = CNT_W'(3);

    // Input item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_BEFORE   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_PROTOCOL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_CMD     = 3'd0,
        PH_REL_LO  = 3'd1,
        PH_LITERAL = 3'd2,
        PH_CNT_LO  = 3'd3,
        PH_CNT_HI  = 3'd4,
        PH_ARG_LO  = 3'd5,
        PH_POS_HI  = 3'd6,
        PH_RUN     = 3'd7
    } t_phase;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [PTR_W-1:0]  out_index;
        logic              byte_valid;
        logic              busy_res;
        logic              done_res;
        t_status           status;
    } t_result;

endpackage

/* src/lz_format80_decompressor_top.sv */
// Format-80 style stream decompressor with an on-chip output image.
// Input channel (i_in_valid / o_in_ready) carries either a compressed stream
// byte (i_command = 0) or a tick (i_command = 1) that releases the next
// pending fill or copy byte. Output channel (o_out_valid / i_out_ready)
// carries at most one result per input transaction: a decoded byte with its
// index, or a final status on the end marker or an error stop.
// Stream bytes, literal bytes and fill ticks can follow back to back while the
// output register is free; a copy tick reads the output image memory at
// accept, and its byte is written back and loaded as a result from the read
// register once the output register is free. Any other result is registered
// and appears in the output register in the cycle after its transaction.
// The output register holds one result; while it is full and the receiver
// stalls, o_in_ready is low for every transaction until the result is taken,
// and a copy tick keeps it low until its byte reaches the output register.
// Reset (synchronous, active low) clears the parser, pointers and the length
// register; the image memory is not cleared and needs no clearing pass, so
// the block is ready as soon as reset is released. After an end marker or an
// error, every transaction is accepted and ignored until reset. i_cfg_we writes
// i_cfg_data into the expected length, by the user only while idle; unchecked.
module lz_format80_decompressor_top #(
    parameter int OUT_SIZE = lzf80_pkg::OUT_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [lzf80_pkg::LEN_W-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [lzf80_pkg::BYTE_W-1:0]  i_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lzf80_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [lzf80_pkg::PTR_W-1:0]   o_out_index,
    output logic                          o_byte_valid,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [2:0]                    o_status
);

    localparam int AW  = $clog2(OUT_SIZE);
    localparam int WPW = AW + 1;
    localparam logic [WPW-1:0] OUT_SIZE_W = WPW'(OUT_SIZE);

    // Control state
    lzf80_pkg::t_phase                   r_phase, n_phase;
    logic [WPW-1:0]                      r_wp, n_wp;
    logic [7:0]                          r_op, n_op;
    logic [lzf80_pkg::CNT_W-1:0]         r_field, n_field;
    logic [lzf80_pkg::CNT_W-1:0]         r_pcnt, n_pcnt;
    logic [lzf80_pkg::PTR_W-1:0]         r_src, n_src;
    logic                                r_is_fill, n_is_fill;
    logic [lzf80_pkg::BYTE_W-1:0]        r_fill, n_fill;
    logic                                r_halted, n_halted;
    logic [lzf80_pkg::LEN_W-1:0]         r_exp_len;

    // Copy read in flight
    logic                                r_rd_pend, n_rd_pend;
    logic [AW-1:0]                       r_pend_idx, n_pend_idx;
    logic                                r_pend_busy, n_pend_busy;

    // Output register
    logic                                r_out_valid, n_out_valid;
    lzf80_pkg::t_result                  r_out;

    // Image memory
    logic [lzf80_pkg::BYTE_W-1:0]        mem [OUT_SIZE];
    logic [lzf80_pkg::BYTE_W-1:0]        r_mem_q;

    logic                                acc;
    logic                                out_free;
    logic                                out_load;
    lzf80_pkg::t_result                  imm_res;
    logic                                imm_valid;
    lzf80_pkg::t_result                  load_res;
    logic                                rd_en;
    logic                                imm_we;
    logic [lzf80_pkg::BYTE_W-1:0]        imm_wdata;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [lzf80_pkg::BYTE_W-1:0]        mem_wdata;
    logic [lzf80_pkg::LEN_W-1:0]         wp_ext;
    logic [lzf80_pkg::LEN_W-1:0]         rel_off;
    logic [lzf80_pkg::CNT_W-1:0]         pcnt_dec;
    logic                                wp_full;

    // Handshake and output register control
    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        o_in_ready  = !r_rd_pend && out_free;
        acc         = i_in_valid && o_in_ready;
        out_load    = (acc && imm_valid) || (r_rd_pend && out_free);
        n_out_valid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign wp_ext   = lzf80_pkg::LEN_W'(r_wp);
    assign rel_off  = lzf80_pkg::LEN_W'(r_field | lzf80_pkg::CNT_W'(i_data));
    assign pcnt_dec = r_pcnt - lzf80_pkg::CNT_W'(1);
    assign wp_full  = (r_wp >= OUT_SIZE_W);

    // Next state: parser, pointers and run bookkeeping
    always_comb begin
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_op        = r_op;
        n_field     = r_field;
        n_pcnt      = r_pcnt;
        n_src       = r_src;
        n_is_fill   = r_is_fill;
        n_fill      = r_fill;
        n_halted    = r_halted;
        n_rd_pend   = r_rd_pend && !out_free;
        n_pend_idx  = r_pend_idx;
        n_pend_busy = r_pend_busy;
        imm_valid   = 1'b0;
        imm_res     = '0;
        imm_we      = 1'b0;
        imm_wdata   = i_data;
        rd_en       = 1'b0;

        if (acc && !r_halted) begin
            if (i_command == lzf80_pkg::CMD_TICK) begin
                if (r_phase == lzf80_pkg::PH_RUN) begin
                    if (wp_full) begin
                        n_halted          = 1'b1;
                        imm_valid         = 1'b1;
                        imm_res.done_res  = 1'b1;
                        imm_res.status    = lzf80_pkg::ST_OVERFLOW;
                    end else begin
                        n_pcnt = pcnt_dec;
                        n_wp   = r_wp + WPW'(1);
                        if (pcnt_dec == '0) begin
                            n_phase = lzf80_pkg::PH_CMD;
                        end
                        if (r_is_fill) begin
                            imm_we             = 1'b1;
                            imm_wdata          = r_fill;
                            imm_valid          = 1'b1;
                            imm_res.out_byte   = r_fill;
                            imm_res.out_index  = lzf80_pkg::PTR_W'(r_wp[AW-1:0]);
                            imm_res.byte_valid = 1'b1;
                            imm_res.busy_res   = (pcnt_dec != '0);
                        end else begin
                            // copy: read now, write back and report once the output register is free
                            rd_en       = 1'b1;
                            n_src       = r_src + lzf80_pkg::PTR_W'(1);
                            n_rd_pend   = 1'b1;
                            n_pend_idx  = r_wp[AW-1:0];
                            n_pend_busy = (pcnt_dec != '0);
                        end
                    end
                end
            end else begin
                case (r_phase)
                    lzf80_pkg::PH_CMD: begin
                        n_op = i_data;
                        if (!i_data[7]) begin
                            n_pcnt  = lzf80_pkg::CNT_W'(i_data[6:4]) +
                                      lzf80_pkg::SHORT_CNT_BIAS;
                            n_field = {4'd0, i_data[3:0], 8'd0};
                            n_phase = lzf80_pkg::PH_REL_LO;
                        end else if (!i_data[6]) begin
                            n_pcnt = lzf80_pkg::CNT_W'(i_data[5:0]);
                            if (i_data[5:0] == '0) begin
                                // end marker
                                n_halted         = 1'b1;
                                imm_valid        = 1'b1;
                                imm_res.done_res = 1'b1;
                                imm_res.status   = (wp_ext == r_exp_len) ?
                                                   lzf80_pkg::ST_OK :
                                                   lzf80_pkg::ST_MISMATCH;
                            end else begin
                                n_phase = lzf80_pkg::PH_LITERAL;
                            end
                        end else if (i_data[5:0] < lzf80_pkg::CNT_LONG_BASE) begin
                            n_pcnt  = lzf80_pkg::CNT_W'(i_data[5:0]) +
                                      lzf80_pkg::SHORT_CNT_BIAS;
                            n_phase = lzf80_pkg::PH_ARG_LO;
                        end else begin
                            n_phase = lzf80_pkg::PH_CNT_LO;
                        end
                    end
                    lzf80_pkg::PH_REL_LO: begin
                        n_field = lzf80_pkg::CNT_W'(rel_off);
                        if (rel_off > wp_ext) begin
                            n_halted         = 1'b1;
                            imm_valid        = 1'b1;
                            imm_res.done_res = 1'b1;
                            imm_res.status   = lzf80_pkg::ST_BEFORE;
                        end else begin
                            n_src     = lzf80_pkg::PTR_W'(wp_ext - rel_off);
                            n_is_fill = 1'b0;
                            n_phase   = (r_pcnt != '0) ? lzf80_pkg::PH_RUN :
                                                         lzf80_pkg::PH_CMD;
                        end
                    end
                    lzf80_pkg::PH_LITERAL: begin
                        if (wp_full) begin
                            n_halted         = 1'b1;
                            imm_valid        = 1'b1;
                            imm_res.done_res = 1'b1;
                            imm_res.status   = lzf80_pkg::ST_OVERFLOW;
                        end else begin
                            n_pcnt = pcnt_dec;
                            n_wp   = r_wp + WPW'(1);
                            if (pcnt_dec == '0) begin
                                n_phase = lzf80_pkg::PH_CMD;
                            end
                            imm_we             = 1'b1;
                            imm_valid          = 1'b1;
                            imm_res.out_byte   = i_data;
                            imm_res.out_index  = lzf80_pkg::PTR_W'(r_wp[AW-1:0]);
                            imm_res.byte_valid = 1'b1;
                        end
                    end
                    lzf80_pkg::PH_CNT_LO: begin
                        n_field = lzf80_pkg::CNT_W'(i_data);
                        n_phase = lzf80_pkg::PH_CNT_HI;
                    end
                    lzf80_pkg::PH_CNT_HI: begin
                        n_pcnt  = {i_data, r_field[7:0]};
                        n_phase = lzf80_pkg::PH_ARG_LO;
                    end
                    lzf80_pkg::PH_ARG_LO: begin
                        if (r_op == lzf80_pkg::OP_LONG_FILL) begin
                            n_fill    = i_data;
                            n_is_fill = 1'b1;
                            n_phase   = (r_pcnt != '0) ? lzf80_pkg::PH_RUN :
                                                         lzf80_pkg::PH_CMD;
                        end else begin
                            n_field = lzf80_pkg::CNT_W'(i_data);
                            n_phase = lzf80_pkg::PH_POS_HI;
                        end
                    end
                    lzf80_pkg::PH_POS_HI: begin
                        n_src     = {i_data, r_field[7:0]};
                        n_is_fill = 1'b0;
                        n_phase   = (r_pcnt != '0) ? lzf80_pkg::PH_RUN :
                                                     lzf80_pkg::PH_CMD;
                    end
                    default: begin
                        // stream byte while a run is pending
                        n_halted         = 1'b1;
                        imm_valid        = 1'b1;
                        imm_res.done_res = 1'b1;
                        imm_res.status   = lzf80_pkg::ST_PROTOCOL;
                    end
                endcase
            end
        end
    end

    // Outputs: memory write port and result selection
    always_comb begin
        load_res = imm_res;
        if (r_rd_pend) begin
            load_res            = '0;
            load_res.out_byte   = r_mem_q;
            load_res.out_index  = lzf80_pkg::PTR_W'(r_pend_idx);
            load_res.byte_valid = 1'b1;
            load_res.busy_res   = r_pend_busy;
        end
        // copy write-back and an immediate write never share a cycle
        mem_we    = (r_rd_pend && out_free) || imm_we;
        mem_waddr = r_rd_pend ? r_pend_idx : r_wp[AW-1:0];
        mem_wdata = r_rd_pend ? r_mem_q : imm_wdata;
    end

    // Image memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_mem_q <= mem[r_src[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lzf80_pkg::PH_CMD;
            r_wp        <= '0;
            r_op        <= '0;
            r_field     <= '0;
            r_pcnt      <= '0;
            r_src       <= '0;
            r_is_fill   <= 1'b0;
            r_fill      <= '0;
            r_halted    <= 1'b0;
            r_exp_len   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_op        <= n_op;
            r_field     <= n_field;
            r_pcnt      <= n_pcnt;
            r_src       <= n_src;
            r_is_fill   <= n_is_fill;
            r_fill      <= n_fill;
            r_halted    <= n_halted;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_exp_len <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_pend_busy <= n_pend_busy;
        if (out_load) begin
            r_out <= load_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_out_index  = r_out.out_index;
    assign o_byte_valid = r_out.byte_valid;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;

endmodule
